/* hdl/fss_pkg.sv */
// Types and constants shared by the file stream session table.
`timescale 1ns / 1ps
package fss_pkg;

  localparam logic [63:0] HEAD_SEQ = 64'hFFFF_FFFF_FFFF_F000;
  localparam logic [15:0] TIMEOUT_RESET = 16'd10;

  localparam logic [2:0] KIND_PUT    = 3'd0;
  localparam logic [2:0] KIND_APPEND = 3'd1;
  localparam logic [2:0] KIND_FINISH = 3'd2;
  localparam logic [2:0] KIND_FAILED = 3'd3;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_NO_SLOT  = 2'd1;
  localparam logic [1:0] STATUS_DATA_REJ = 2'd2;
  localparam logic [1:0] STATUS_HEAD_ERR = 2'd3;

  typedef struct packed {
    logic [63:0] stream_id;
    logic [63:0] sequence_req;
    logic [63:0] ack_count;
    logic [15:0] payload_length;
    logic [2:0]  head_kind;
    logic [63:0] append_offset;
    logic [31:0] now_seconds;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  slot_index;
    logic        write_enable;
    logic [63:0] write_offset;
    logic [15:0] write_length;
  } rsp_t;

endpackage

/* hdl/file_stream_session_table_core.sv */
// Session table top level: slot search over a row memory and session update.
//
//   channel   direction  handshake                    payload
//   request   in         start high, busy low         req_i (fss_pkg::req_t)
//   result    out        done_o for one cycle         rsp_o (fss_pkg::rsp_t)
//   config    in         cfg_valid_i && cfg_ready_o   cfg_data_i (idle_timeout)
//
// A request keeps busy high while the search reads the row memory once per slot,
// while the chosen row is read and while that row is updated. done_o rises as
// busy falls; a new request is accepted only once busy is low, which may be
// while done_o is still high. A request that finds no slot skips the update
// and drops busy after the pick. Reset clears the slot flags at once; rows never
// written read as zero. The result cannot be stalled.
`timescale 1ns / 1ps
module file_stream_session_table_core #(
  parameter int SLOT_COUNT = 16,
  parameter int ID_BITS    = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  fss_pkg::req_t req_i,
  output logic          done_o,
  output fss_pkg::rsp_t rsp_o,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [15:0]   cfg_data_i
);

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CNT_W = $clog2(SLOT_COUNT + 1);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_PICK   = 2'd2;
  localparam logic [1:0] S_UPDATE = 2'd3;

  typedef struct packed {
    logic [ID_BITS-1:0] id;
    logic [31:0]        last_seen;
    logic               open;
    logic [63:0]        exp_seq;
    logic [63:0]        exp_ack;
  } row_t;

  row_t mem [SLOT_COUNT];
  row_t rd_row_q;
  logic [IDX_W-1:0] rd_addr_q;

  logic [1:0]            state_q, state_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [SLOT_COUNT-1:0] active_q, active_d;
  logic [SLOT_COUNT-1:0] valid_q, valid_d;
  logic [15:0]           timeout_q, timeout_d;
  logic                  done_q, done_d;
  logic                  match_q, match_d, free_q, free_d, stale_q, stale_d;
  logic [IDX_W-1:0]      match_idx_q, match_idx_d, free_idx_q, free_idx_d;
  logic [IDX_W-1:0]      stale_idx_q, stale_idx_d, sel_q, sel_d;
  fss_pkg::req_t         req_q, req_d;
  fss_pkg::rsp_t         rsp_q, rsp_d;

  logic             rd_en, wr_en;
  logic [IDX_W-1:0] rd_addr;
  row_t             row, wr_row;
  logic [31:0]      idle_age;

  assign busy        = (state_q != S_IDLE);
  assign done_o      = done_q;
  assign rsp_o       = rsp_q;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    row      = valid_q[rd_addr_q] ? rd_row_q : '0;
    idle_age = req_q.now_seconds - row.last_seen;

    state_d     = state_q;
    cnt_d       = cnt_q;
    active_d    = active_q;
    valid_d     = valid_q;
    timeout_d   = timeout_q;
    done_d      = 1'b0;
    match_d     = match_q;
    free_d      = free_q;
    stale_d     = stale_q;
    match_idx_d = match_idx_q;
    free_idx_d  = free_idx_q;
    stale_idx_d = stale_idx_q;
    sel_d       = sel_q;
    req_d       = req_q;
    rsp_d       = rsp_q;
    rd_en       = 1'b0;
    rd_addr     = '0;
    wr_en       = 1'b0;
    wr_row      = row;

    if (cfg_valid_i) begin
      timeout_d = cfg_data_i;
    end

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          req_d   = req_i;
          match_d = 1'b0;
          free_d  = 1'b0;
          stale_d = 1'b0;
          rd_en   = 1'b1;
          rd_addr = '0;
          cnt_d   = CNT_W'(1);
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (active_q[rd_addr_q] && !match_q &&
            row.id == req_q.stream_id[ID_BITS-1:0]) begin
          match_d     = 1'b1;
          match_idx_d = rd_addr_q;
        end
        if (!active_q[rd_addr_q] && !free_q) begin
          free_d     = 1'b1;
          free_idx_d = rd_addr_q;
        end
        if (idle_age >= {16'd0, timeout_q} && !stale_q) begin
          stale_d     = 1'b1;
          stale_idx_d = rd_addr_q;
        end
        if (cnt_q == CNT_W'(SLOT_COUNT)) begin
          state_d = S_PICK;
        end else begin
          rd_en   = 1'b1;
          rd_addr = cnt_q[IDX_W-1:0];
          cnt_d   = cnt_q + CNT_W'(1);
        end
      end
      S_PICK: begin
        priority if (match_q) begin
          sel_d = match_idx_q;
        end else if (free_q) begin
          sel_d = free_idx_q;
        end else begin
          sel_d = stale_idx_q;
        end
        if (match_q || free_q || stale_q) begin
          rd_en   = 1'b1;
          rd_addr = sel_d;
          state_d = S_UPDATE;
        end else begin
          rsp_d        = '0;
          rsp_d.status = fss_pkg::STATUS_NO_SLOT;
          done_d       = 1'b1;
          state_d      = S_IDLE;
        end
      end
      S_UPDATE: begin
        rsp_d            = '0;
        rsp_d.status     = fss_pkg::STATUS_OK;
        rsp_d.slot_index = 4'(sel_q);
        wr_row.id        = req_q.stream_id[ID_BITS-1:0];
        wr_row.last_seen = req_q.now_seconds;
        active_d[sel_q]  = 1'b1;
        valid_d[sel_q]   = 1'b1;
        if (req_q.sequence_req == fss_pkg::HEAD_SEQ) begin
          wr_row.open = 1'b0;
          unique case (req_q.head_kind)
            fss_pkg::KIND_PUT: begin
              wr_row.open    = 1'b1;
              wr_row.exp_seq = '0;
              wr_row.exp_ack = req_q.ack_count;
            end
            fss_pkg::KIND_APPEND: begin
              wr_row.open    = 1'b1;
              wr_row.exp_seq = req_q.append_offset;
              wr_row.exp_ack = req_q.ack_count;
            end
            fss_pkg::KIND_FINISH: begin
              active_d[sel_q] = 1'b0;
            end
            fss_pkg::KIND_FAILED: begin
              active_d[sel_q] = 1'b0;
              rsp_d.status    = fss_pkg::STATUS_HEAD_ERR;
            end
            default: begin
            end
          endcase
        end else if (!row.open || row.exp_ack != req_q.ack_count ||
                     row.exp_seq != req_q.sequence_req) begin
          wr_row.open     = 1'b0;
          active_d[sel_q] = 1'b0;
          rsp_d.status    = fss_pkg::STATUS_DATA_REJ;
        end else if (req_q.payload_length != 16'd0) begin
          rsp_d.write_enable = 1'b1;
          rsp_d.write_offset = row.exp_seq;
          rsp_d.write_length = req_q.payload_length;
          wr_row.exp_seq     = row.exp_seq + {48'd0, req_q.payload_length};
        end
        wr_en   = 1'b1;
        done_d  = 1'b1;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      active_q  <= '0;
      valid_q   <= '0;
      timeout_q <= fss_pkg::TIMEOUT_RESET;
      done_q    <= 1'b0;
      match_q   <= 1'b0;
      free_q    <= 1'b0;
      stale_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      active_q  <= active_d;
      valid_q   <= valid_d;
      timeout_q <= timeout_d;
      done_q    <= done_d;
      match_q   <= match_d;
      free_q    <= free_d;
      stale_q   <= stale_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q       <= req_d;
    rsp_q       <= rsp_d;
    match_idx_q <= match_idx_d;
    free_idx_q  <= free_idx_d;
    stale_idx_q <= stale_idx_d;
    sel_q       <= sel_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[sel_q] <= wr_row;
    end
    if (rd_en) begin
      rd_row_q  <= mem[rd_addr];
      rd_addr_q <= rd_addr;
    end
  end

endmodule

/* hdl/fss_chk.sv */
// Port-level checker for the session table and its bind to the top level.
`timescale 1ns / 1ps
module fss_chk (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start,
  input logic          busy,
  input logic          done_o,
  input fss_pkg::rsp_t rsp_o
);

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("busy not raised after request");

  a_done_on_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o)
    else $error("request finished without result");

  a_single_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  a_no_slot_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && rsp_o.status == fss_pkg::STATUS_NO_SLOT |->
      rsp_o.slot_index == 4'd0 && !rsp_o.write_enable)
    else $error("no-slot result carries slot or write");

  a_idle_write_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !rsp_o.write_enable |->
      rsp_o.write_offset == 64'd0 && rsp_o.write_length == 16'd0)
    else $error("write fields set without write enable");

endmodule

bind file_stream_session_table_core fss_chk u_fss_chk (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .done_o (done_o),
  .rsp_o  (rsp_o)
);
